/* design/clock_sync_offset_pi_defines.svh */
// Assertion macros used by the checker file.
`ifndef CLOCK_SYNC_OFFSET_PI_DEFINES_SVH
`define CLOCK_SYNC_OFFSET_PI_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSOP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSOP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/csop_pkg.sv */
package csop_pkg;

    localparam int TIME_W    = 63;
    localparam int REG_W     = 30;
    localparam int OFF_W     = 28;
    localparam int PH_W      = 31;
    localparam int CFG_IDX_W = 2;
    localparam int PROP_W    = 7;
    localparam int INT_W     = 5;

    localparam logic [REG_W-1:0] CYCLE_TIME_RESET = 30'd1000000;
    localparam logic [REG_W-1:0] SYNC_SHIFT_RESET = 30'd50000;

    localparam logic [PROP_W-1:0] PROP_DIV = 7'd100;
    localparam logic [INT_W-1:0]  INT_DIV  = 5'd20;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SHIFT = 2'd1;

endpackage

/* design/csop_sdiv.sv */
module csop_sdiv #(
    parameter int N = 63,
    parameter int D = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);

    localparam int CW = $clog2(N + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [N-1:0]  acc_reg;
    logic [N-1:0]  acc_next;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  rem_next;
    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          fits;

    assign busy      = (cnt_reg != '0);
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, acc_reg[N-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CW'(N);
            acc_next = dividend;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            acc_next = {acc_reg[N-2:0], fits};
            rem_next = fits ? diff[D-1:0] : trial[D-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

endmodule

/* design/clock_sync_offset_pi.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     reference_time
// out       output     out_valid / out_stall   offset_ns, phase_error
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The remainder modulo cycle_time is formed one bit per cycle, then the
// divisions by 100 and by 20 run side by side one quotient bit per cycle.
// A new item is accepted while a finished result still waits in the output register.
// Reset clears the integrator and loads the register reset values; cfg_ready is always high.
module clock_sync_offset_pi #(
    parameter int INTEGRATOR_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [csop_pkg::TIME_W-1:0]          reference_time,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [csop_pkg::OFF_W-1:0]    offset_ns,
    output logic signed [csop_pkg::PH_W-1:0]     phase_error,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csop_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csop_pkg::REG_W-1:0]           cfg_data
);

    import csop_pkg::*;

    localparam int IB = INTEGRATOR_BITS;
    localparam int SW = ((IB > REG_W) ? IB : REG_W) + 2;

    localparam logic signed [IB-1:0] IMAX = {1'b0, {(IB-1){1'b1}}};
    localparam logic signed [IB-1:0] IMIN = {1'b1, {(IB-1){1'b0}}};
    localparam logic signed [SW-1:0] OMAX = {{(SW-OFF_W+1){1'b0}}, {(OFF_W-1){1'b1}}};
    localparam logic signed [SW-1:0] OMIN = {{(SW-OFF_W+1){1'b1}}, {(OFF_W-1){1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MOD   = 6'b000010,
        ST_WRAP  = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [REG_W-1:0]        cycle_time_reg;
    logic [REG_W-1:0]        sync_shift_reg;
    logic signed [IB-1:0]    integ_reg;
    logic signed [IB-1:0]    integ_next;
    logic                    neg_reg;
    logic signed [PH_W-1:0]  delta_reg;
    logic signed [PH_W-1:0]  delta_next;
    logic                    out_valid_reg;
    logic signed [OFF_W-1:0] offset_reg;
    logic signed [PH_W-1:0]  phase_reg;

    logic                    in_accept;
    logic                    out_free;
    logic [REG_W-1:0]        ct_eff;
    logic [TIME_W-1:0]       shift_ext;
    logic                    time_ge;
    logic [TIME_W-1:0]       mag;
    logic                    mod_busy;
    logic [TIME_W-1:0]       mod_quot;
    logic [REG_W-1:0]        mod_rem;
    logic                    div_start;
    logic [REG_W-1:0]        delta_mag;
    logic [IB-1:0]           integ_mag;
    logic                    pdiv_busy;
    logic [REG_W-1:0]        pdiv_quot;
    logic [PROP_W-1:0]       pdiv_rem;
    logic                    idiv_busy;
    logic [IB-1:0]           idiv_quot;
    logic [INT_W-1:0]        idiv_rem;
    logic signed [SW-1:0]    prop_term;
    logic signed [SW-1:0]    int_term;
    logic signed [SW-1:0]    sum;
    logic signed [OFF_W-1:0] offset_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign offset_ns = offset_reg;
    assign phase_error = phase_reg;
    assign cfg_ready = 1'b1;

    // A zero cycle time acts as a modulus of one.
    assign ct_eff    = (cycle_time_reg == '0) ? REG_W'(1) : cycle_time_reg;
    assign shift_ext = {{(TIME_W-REG_W){1'b0}}, sync_shift_reg};
    assign time_ge   = (reference_time >= shift_ext);
    assign mag       = time_ge ? (reference_time - shift_ext) : (shift_ext - reference_time);

    csop_sdiv #(
        .N (TIME_W),
        .D (REG_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (mag),
        .divisor   (ct_eff),
        .busy      (mod_busy),
        .quotient  (mod_quot),
        .remainder (mod_rem)
    );

    // Remainder takes the sign of the difference; a non-negative one wraps past half a cycle.
    always_comb
    begin
        if (neg_reg)
            delta_next = -$signed({1'b0, mod_rem});
        else if (mod_rem > (ct_eff >> 1))
            delta_next = $signed({1'b0, mod_rem}) - $signed({1'b0, ct_eff});
        else
            delta_next = $signed({1'b0, mod_rem});
    end

    always_comb
    begin
        integ_next = integ_reg;
        if (!delta_next[PH_W-1] && (delta_next != '0) && (integ_reg != IMAX))
            integ_next = integ_reg + 1'b1;
        else if (delta_next[PH_W-1] && (integ_reg != IMIN))
            integ_next = integ_reg - 1'b1;
    end

    assign div_start = (state_reg == ST_START);
    assign delta_mag = delta_reg[PH_W-1] ? REG_W'(-delta_reg) : REG_W'(delta_reg);
    assign integ_mag = integ_reg[IB-1] ? (~integ_reg + 1'b1) : integ_reg;

    csop_sdiv #(
        .N (REG_W),
        .D (PROP_W)
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (delta_mag),
        .divisor   (PROP_DIV),
        .busy      (pdiv_busy),
        .quotient  (pdiv_quot),
        .remainder (pdiv_rem)
    );

    csop_sdiv #(
        .N (IB),
        .D (INT_W)
    ) u_idiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (integ_mag),
        .divisor   (INT_DIV),
        .busy      (idiv_busy),
        .quotient  (idiv_quot),
        .remainder (idiv_rem)
    );

    // Both terms enter negated: restore the truncated quotient's sign, then flip it.
    assign prop_term = delta_reg[PH_W-1] ? $signed(SW'(pdiv_quot)) : -$signed(SW'(pdiv_quot));
    assign int_term  = integ_reg[IB-1] ? $signed(SW'(idiv_quot)) : -$signed(SW'(idiv_quot));
    assign sum       = prop_term + int_term;

    always_comb
    begin
        if (sum > OMAX)
            offset_sat = OMAX[OFF_W-1:0];
        else if (sum < OMIN)
            offset_sat = OMIN[OFF_W-1:0];
        else
            offset_sat = sum[OFF_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (!mod_busy)
                    state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!pdiv_busy && !idiv_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cycle_time_reg <= CYCLE_TIME_RESET;
            sync_shift_reg <= SYNC_SHIFT_RESET;
            integ_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CYCLE_TIME: cycle_time_reg <= cfg_data;
                    REG_SYNC_SHIFT: sync_shift_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (state_reg == ST_WRAP)
                integ_reg <= integ_next;
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            neg_reg <= !time_ge;
        if (state_reg == ST_WRAP)
            delta_reg <= delta_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            offset_reg <= offset_sat;
            phase_reg  <= delta_reg;
        end
    end

endmodule

/* design/csop_checker.sv */
`include "clock_sync_offset_pi_defines.svh"

module csop_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [csop_pkg::OFF_W-1:0] offset_ns,
    input logic signed [csop_pkg::PH_W-1:0]  phase_error
);

    import csop_pkg::*;

    // Hold a stalled result.
    `CSOP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(offset_ns) && $stable(phase_error), "stalled result changed")

    // An accepted item keeps the input side busy for the next cycle.
    `CSOP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after a transaction")

    // A new result appears only at the end of work on an item.
    `CSOP_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result without an item in progress")

endmodule

bind clock_sync_offset_pi csop_checker u_csop_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .offset_ns   (offset_ns),
    .phase_error (phase_error)
);
